// ----- rtl/assert_macros.svh -----
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sfef_pkg.sv -----
`default_nettype none
package sfef_pkg;

  localparam int ID_W   = 16;
  localparam int WGT_W  = 32;
  localparam int RANK_W = 5;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam int DEF_MAX_SEGMENTS = 65536;
  localparam int ID_SPACE         = 65536;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    K_EDGE    = 2'd0,
    K_RESTART = 2'd1,
    K_SKIP    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WGT_W-1:0]  weight;
    logic [ID_W-1:0]   seg_a;
    logic [ID_W-1:0]   seg_b;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/spanning_forest_edge_filter.sv -----
// Channel | Dir | tdata (low bit up)                          | tuser
// s_*     | in  | edge_weight[31:0] seg_a[47:32] seg_b[63:48] | action
// m_*     | out | out_weight[31:0] out_seg_a[47:32] out_seg_b[63:48] | accepted
//
// Edge: the back end follows parent pointers from seg_a and then from seg_b to their roots
//   (one parent-memory read per hop), then reads both ranks when the roots are joined.
// Out-of-range edge: finished in S_IDLE with no store access. The result is registered.
// Restart: a sweep of one store entry per cycle over min(MAX_SEGMENTS, 65536) entries.
// Reset runs the same sweep; no transaction leaves the back end until it ends.
// The front register and 4-entry queue keep taking input while the back end works
// or while a result waits on m_tready, until the queue and the front register are full.
`default_nettype none
module spanning_forest_edge_filter
  import sfef_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // edge_weight, seg_a, seg_b
  input  wire logic        s_tuser,   // action
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // out_weight, out_seg_a, out_seg_b
  output      logic        m_tuser    // accepted
);

  logic  push, q_full, q_nempty, pop;
  item_t f_item, q_head;
  logic [WGT_W-1:0] o_w;
  logic [ID_W-1:0]  o_a, o_b;

  // front: register and classify each transaction
  sfef_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .action(s_tuser),
    .edge_weight(s_tdata[31:0]),
    .seg_a(s_tdata[47:32]),
    .seg_b(s_tdata[63:48]),
    .push, .q_full, .item(f_item)
  );

  sfef_queue u_queue (
    .clk, .rst,
    .push, .push_item(f_item), .full(q_full),
    .pop, .nempty(q_nempty), .head(q_head)
  );

  // back: union-find store, root searches, join by rank
  sfef_core #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_core (
    .clk, .rst,
    .q_nempty, .q_head, .pop,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .accepted(m_tuser), .out_weight(o_w), .out_seg_a(o_a), .out_seg_b(o_b)
  );

  assign m_tdata = {o_b, o_a, o_w};

endmodule
`default_nettype wire

// ----- rtl/sfef_front.sv -----
`default_nettype none
module sfef_front
  import sfef_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              action,
  input  wire logic [WGT_W-1:0]  edge_weight,
  input  wire logic [ID_W-1:0]   seg_a,
  input  wire logic [ID_W-1:0]   seg_b,
  output      logic              push,
  input  wire logic              q_full,
  output      item_t             item
);

  // ids at or above the limit never touch the store
  localparam logic [ID_W:0] ID_LIM =
    (MAX_SEGMENTS >= ID_SPACE) ? (ID_W+1)'(ID_SPACE) : (ID_W+1)'(MAX_SEGMENTS);

  logic  fvalid;
  item_t fitem;
  logic  ids_ok;

  assign ids_ok   = ({1'b0, seg_a} < ID_LIM) && ({1'b0, seg_b} < ID_LIM);
  assign push     = fvalid && !q_full;
  assign in_ready = !fvalid || !q_full;
  assign item     = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (in_ready) begin
      fvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fitem.kind   <= action ? K_RESTART : (ids_ok ? K_EDGE : K_SKIP);
      fitem.weight <= edge_weight;
      fitem.seg_a  <= seg_a;
      fitem.seg_b  <= seg_b;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sfef_queue.sv -----
`default_nettype none
`include "assert_macros.svh"
module sfef_queue
  import sfef_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  nempty,
  output      item_t head
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   cnt;

  assign full   = (cnt == (QPTR_W+1)'(QDEPTH));
  assign nempty = (cnt != '0);
  assign head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  `ASSERT_IMP(a_no_overfill, full, !push, "push into full queue")
  `ASSERT_IMP(a_no_underrun, !nempty, !pop, "pop from empty queue")

endmodule
`default_nettype wire

// ----- rtl/sfef_core.sv -----
`default_nettype none
`include "assert_macros.svh"
module sfef_core
  import sfef_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_nempty,
  input  wire item_t             q_head,
  output      logic              pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              accepted,
  output      logic [WGT_W-1:0]  out_weight,
  output      logic [ID_W-1:0]   out_seg_a,
  output      logic [ID_W-1:0]   out_seg_b
);

  localparam int DEPTH = (MAX_SEGMENTS >= ID_SPACE) ? ID_SPACE : MAX_SEGMENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_FA    = 6'b000100,
    S_FB    = 6'b001000,
    S_RA    = 6'b010000,
    S_RB    = 6'b100000
  } state_t;

  state_t st, st_next;

  logic [ID_W-1:0]   pmem [DEPTH];
  logic [RANK_W-1:0] rmem [DEPTH];
  logic [ID_W-1:0]   prd;
  logic [RANK_W-1:0] rrd;

  logic [AW-1:0]     p_ra, p_wa, r_ra, r_wa;
  logic [ID_W-1:0]   p_wd;
  logic [RANK_W-1:0] r_wd;
  logic              p_we, r_we;

  item_t             itm;
  logic [ID_W-1:0]   cur, ra, rb;
  logic [RANK_W-1:0] rka;
  logic [AW-1:0]     cnt;
  logic              reply;
  logic              done, done_acc;
  logic              ovalid;

  assign out_valid = ovalid;

  always_comb begin
    st_next  = st;
    pop      = 1'b0;
    done     = 1'b0;
    done_acc = 1'b0;
    p_ra     = '0;
    r_ra     = '0;
    p_we     = 1'b0;
    p_wa     = '0;
    p_wd     = '0;
    r_we     = 1'b0;
    r_wa     = '0;
    r_wd     = '0;
    case (st)
      S_IDLE: begin
        if (q_nempty && !ovalid) begin
          pop = 1'b1;
          case (q_head.kind)
            K_RESTART: st_next = S_CLEAR;
            K_EDGE: begin
              p_ra    = q_head.seg_a[AW-1:0];
              st_next = S_FA;
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_CLEAR: begin
        p_we = 1'b1;
        p_wa = cnt;
        p_wd = ID_W'(cnt);
        r_we = 1'b1;
        r_wa = cnt;
        if (cnt == LAST) begin
          done    = reply;
          st_next = S_IDLE;
        end
      end
      S_FA: begin
        if (prd == cur) begin
          p_ra    = itm.seg_b[AW-1:0];
          st_next = S_FB;
        end else begin
          p_ra = prd[AW-1:0];
        end
      end
      S_FB: begin
        if (prd == cur) begin
          if (cur != ra && ra != '0 && cur != '0) begin
            r_ra    = ra[AW-1:0];
            st_next = S_RA;
          end else begin
            done    = 1'b1;
            st_next = S_IDLE;
          end
        end else begin
          p_ra = prd[AW-1:0];
        end
      end
      S_RA: begin
        r_ra    = rb[AW-1:0];
        st_next = S_RB;
      end
      S_RB: begin
        p_we     = 1'b1;
        done     = 1'b1;
        done_acc = 1'b1;
        st_next  = S_IDLE;
        if (rka >= rrd) begin
          p_wa = rb[AW-1:0];
          p_wd = ra;
          if (rka == rrd && rka != RANK_MAX) begin
            r_we = 1'b1;
            r_wa = ra[AW-1:0];
            r_wd = rka + 1'b1;
          end
        end else begin
          p_wa = ra[AW-1:0];
          p_wd = rb;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prd <= pmem[p_ra];
    rrd <= rmem[r_ra];
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    if (r_we) begin
      rmem[r_wa] <= r_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_CLEAR;
      cnt    <= '0;
      reply  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == S_CLEAR) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (pop) begin
        reply <= (q_head.kind == K_RESTART);
      end
      if (done) begin
        ovalid <= 1'b1;
      end else if (out_ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      itm <= q_head;
      cur <= q_head.seg_a;
    end
    if (st == S_FA && prd == cur) begin
      ra  <= cur;
      cur <= itm.seg_b;
    end else if ((st == S_FA || st == S_FB) && prd != cur) begin
      cur <= prd;
    end
    if (st == S_FB && prd == cur) begin
      rb <= cur;
    end
    if (st == S_RA) begin
      rka <= rrd;
    end
    if (done) begin
      accepted   <= done_acc;
      out_weight <= pop ? q_head.weight : itm.weight;
      out_seg_a  <= pop ? q_head.seg_a : itm.seg_a;
      out_seg_b  <= pop ? q_head.seg_b : itm.seg_b;
    end
  end

  `ASSERT_IMP(a_join_distinct, st == S_RB, ra != rb && ra != '0 && rb != '0, "join of bad roots")
  `ASSERT_IMP(a_clear_no_pending, st == S_CLEAR, !ovalid, "store sweep with result pending")
  `ASSERT_NXT(a_done_sets_valid, done, ovalid, "finished transaction not presented")

endmodule
`default_nettype wire
